// ----- design/vras_pkg.sv -----
package vras_pkg;

	// register space, in word addresses (byte offset >> 2)
	localparam int ADDR_W = 9;
	localparam int WORD_W = 7;
	localparam int DATA_W = 32;

	localparam logic [WORD_W-1:0] WORD_INSTR = 7'd0;
	localparam logic [WORD_W-1:0] WORD_STATUS = 7'd1;

	// instruction layout
	localparam int INSTR_W = 17;
	localparam logic [7:0] OPC_ADD = 8'd1;
	localparam logic [7:0] OPC_SUB = 8'd2;

	// status bits
	localparam int STAT_CLR_BIT = 2;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [INSTR_W-1:0] instr_t;

endpackage

// ----- design/vector_register_add_sub_device.sv -----
// each access passes through the input register, then the result register,
// whose contents are offered as the result
// throughput: one access per cycle while out_stall does not hold the output; an instruction write runs the whole
// elementwise add or subtract in one pass through the lane adders
// reset: asynchronous, clears the vector file, instruction and status flags
module vector_register_add_sub_device #(
	parameter int NUM_ELEMENTS = 4,
	parameter int NUM_VECTORS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [vras_pkg::ADDR_W-1:0] addr,
	input  logic [vras_pkg::DATA_W-1:0] wdata,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [vras_pkg::DATA_W-1:0] rdata
);

	localparam int VW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
	localparam int EW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
	localparam logic [3:0] NV_C = 4'(NUM_VECTORS);
	localparam logic [2:0] NE_C = 3'(NUM_ELEMENTS);

	// input stage
	logic                        valid_s1;
	logic                        op_s1;
	logic [vras_pkg::ADDR_W-1:0] addr_s1;
	vras_pkg::word_t             wdata_s1;

	// architectural state
	vras_pkg::word_t vec_q [NUM_VECTORS][NUM_ELEMENTS];
	vras_pkg::instr_t instr_q;
	logic done_q;
	logic error_q;

	// result register
	logic            out_valid_q;
	vras_pkg::word_t rdata_q;

	logic s1_free;
	logic s1_adv;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv = valid_s1 && out_free;
	assign s1_free = !valid_s1 || s1_adv;
	assign in_stall = !s1_free;

	assign out_valid = out_valid_q;
	assign rdata = rdata_q;

	// address decode
	logic [vras_pkg::WORD_W-1:0] word_s1;
	logic [3:0] vsel;
	logic [1:0] esel;
	logic slot_ok;

	assign word_s1 = addr_s1[vras_pkg::ADDR_W-1:2];
	assign vsel = addr_s1[7:4];
	assign esel = addr_s1[3:2];
	assign slot_ok = addr_s1[8] && (vsel < NV_C) && ({1'b0, esel} < NE_C);

	// instruction decode from the write data
	vras_pkg::instr_t instr_new;
	logic [7:0] opc;
	logic [2:0] ra;
	logic [2:0] rb;
	logic [2:0] rd;
	logic exec_ok;
	logic is_sub;

	assign instr_new = wdata_s1[vras_pkg::INSTR_W-1:0];
	assign opc = instr_new[7:0];
	assign ra = instr_new[10:8];
	assign rb = instr_new[13:11];
	assign rd = instr_new[16:14];
	assign is_sub = (opc == vras_pkg::OPC_SUB);
	assign exec_ok = ((opc == vras_pkg::OPC_ADD) || is_sub)
		&& ({1'b0, ra} < NV_C) && ({1'b0, rb} < NV_C) && ({1'b0, rd} < NV_C);

	// one adder per lane
	vras_pkg::word_t res [NUM_ELEMENTS];

	always_comb begin
		for (int e = 0; e < NUM_ELEMENTS; e++) begin
			if (is_sub) begin
				res[e] = vec_q[ra[VW-1:0]][e] - vec_q[rb[VW-1:0]][e];
			end else begin
				res[e] = vec_q[ra[VW-1:0]][e] + vec_q[rb[VW-1:0]][e];
			end
		end
	end

	// read mux
	vras_pkg::word_t rd_mux;

	always_comb begin
		rd_mux = '0;
		if (!op_s1) begin
			unique case (word_s1)
				vras_pkg::WORD_INSTR: begin
					rd_mux = vras_pkg::DATA_W'(instr_q);
				end
				vras_pkg::WORD_STATUS: begin
					rd_mux = vras_pkg::DATA_W'({error_q, done_q});
				end
				default: begin
					if (slot_ok) begin
						rd_mux = vec_q[vsel[VW-1:0]][esel[EW-1:0]];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			op_s1 <= op;
			addr_s1 <= addr;
			wdata_s1 <= wdata;
		end
	end

	// state update on the transfer out of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VECTORS; v++) begin
				for (int e = 0; e < NUM_ELEMENTS; e++) begin
					vec_q[v][e] <= '0;
				end
			end
			instr_q <= '0;
			done_q <= 1'b0;
			error_q <= 1'b0;
		end else if (s1_adv && op_s1) begin
			unique case (word_s1)
				vras_pkg::WORD_INSTR: begin
					instr_q <= instr_new;
					done_q <= 1'b1;
					error_q <= !exec_ok;
					if (exec_ok) begin
						for (int e = 0; e < NUM_ELEMENTS; e++) begin
							vec_q[rd[VW-1:0]][e] <= res[e];
						end
					end
				end
				vras_pkg::WORD_STATUS: begin
					if (wdata_s1[vras_pkg::STAT_CLR_BIT]) begin
						done_q <= 1'b0;
						error_q <= 1'b0;
					end
				end
				default: begin
					if (slot_ok) begin
						vec_q[vsel[VW-1:0]][esel[EW-1:0]] <= wdata_s1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rdata_q <= rd_mux;
		end
	end

`ifndef NO_ASSERTIONS
	a_err_implies_done: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |-> done_q)
		else $error("error flag set without done");

	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && op_s1 && word_s1 == vras_pkg::WORD_STATUS
			&& wdata_s1[vras_pkg::STAT_CLR_BIT]) |=> (!done_q && !error_q))
		else $error("status clear did not take effect");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && op_s1) |=> (out_valid_q && rdata_q == '0))
		else $error("write transfer produced nonzero read data");

	a_instr_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && op_s1 && word_s1 == vras_pkg::WORD_INSTR) |=> done_q)
		else $error("instruction write did not set done");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");
`endif

endmodule
